// ===== rtl/ffpa_pkg.sv =====
// Package with the shared types and codes of the first-fit pool allocator.
package ffpa_pkg;

   localparam int ADDR_BITS        = 16;
   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int HEADER_BYTES_DEF = 24;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;
   localparam logic [1:0] STATUS_BAD     = 2'd3;

   localparam logic [1:0] MODE_SEARCH = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;
   localparam logic [1:0] MODE_PASS   = 2'd3;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic [15:0]          alloc_size;
      logic [15:0]          free_address;
   } req_type;

   typedef struct packed {
      logic [15:0]          address;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic                 free;
      logic [ADDR_BITS-1:0] start;
      logic [ADDR_BITS-1:0] payload;
   } seg_type;

   // Request token that walks down the cell row one cell per cycle.
   typedef struct packed {
      logic                 active;
      logic [1:0]           mode;
      logic                 op_free;
      logic [ADDR_BITS-1:0] key;
      logic                 room;
      seg_type              carry;
      logic                 shift2;
      logic [ADDR_BITS-1:0] address;
      logic [1:0]           status;
   } tok_type;

endpackage

// ===== rtl/ffpa_cell.sv =====
// One segment cell: holds a table entry and acts on the passing request token.
module ffpa_cell #(
   parameter int HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              init,
   input  ffpa_pkg::seg_type init_seg,
   input  ffpa_pkg::tok_type tok_i,
   input  ffpa_pkg::seg_type nxt1,
   input  ffpa_pkg::seg_type nxt2,
   output ffpa_pkg::seg_type seg_o,
   output ffpa_pkg::tok_type tok_o
);

   localparam int AB = ffpa_pkg::ADDR_BITS;
   localparam logic [AB:0] HDR = (AB+1)'(HEADER_BYTES);

   ffpa_pkg::seg_type seg_ff, seg_in;
   ffpa_pkg::tok_type tok_ff, tok_in;

   logic [AB:0] here_addr, next_addr, key_x, size_x, rem_x, merge1, merge2;
   logic        match_here, match_next;

   always_comb begin
      here_addr  = {1'b0, seg_ff.start} + HDR;
      next_addr  = {1'b0, nxt1.start} + HDR;
      key_x      = {1'b0, tok_i.key};
      size_x     = key_x + HDR;
      rem_x      = {1'b0, seg_ff.payload} - size_x;
      merge1     = {1'b0, seg_ff.payload} + {1'b0, nxt1.payload} + HDR;
      merge2     = merge1 + {1'b0, nxt2.payload} + HDR;
      match_here = seg_ff.valid && (here_addr == key_x);
      match_next = nxt1.valid && (next_addr == key_x);
   end

   always_comb begin
      seg_in = seg_ff;
      tok_in = tok_i;
      if (tok_i.active) begin
         unique case (tok_i.mode)
            ffpa_pkg::MODE_SEARCH: begin
               if (!seg_ff.valid) begin
                  tok_in.mode    = ffpa_pkg::MODE_PASS;
                  tok_in.address = '0;
                  tok_in.status  = tok_i.op_free ? ffpa_pkg::STATUS_BAD
                                                 : ffpa_pkg::STATUS_NO_FIT;
               end else if (!tok_i.op_free) begin
                  if (seg_ff.free && (seg_ff.payload >= tok_i.key)) begin
                     seg_in.free    = 1'b0;
                     tok_in.address = here_addr[AB-1:0];
                     tok_in.status  = ffpa_pkg::STATUS_OK;
                     tok_in.mode    = ffpa_pkg::MODE_PASS;
                     if (({1'b0, seg_ff.payload} > size_x) && tok_i.room) begin
                        seg_in.payload       = tok_i.key;
                        tok_in.mode          = ffpa_pkg::MODE_INSERT;
                        tok_in.carry.valid   = 1'b1;
                        tok_in.carry.free    = 1'b1;
                        tok_in.carry.start   = AB'(here_addr + key_x);
                        tok_in.carry.payload = rem_x[AB-1:0];
                     end
                  end
               end else begin
                  // A free predecessor absorbs the freed segment and maybe its successor.
                  if (seg_ff.free && match_next) begin
                     tok_in.status = ffpa_pkg::STATUS_OK;
                     tok_in.mode   = ffpa_pkg::MODE_DELETE;
                     if (nxt2.valid && nxt2.free) begin
                        seg_in.payload = merge2[AB-1:0];
                        tok_in.shift2  = 1'b1;
                     end else begin
                        seg_in.payload = merge1[AB-1:0];
                        tok_in.shift2  = 1'b0;
                     end
                  end else if (match_here) begin
                     seg_in.free   = 1'b1;
                     tok_in.status = ffpa_pkg::STATUS_OK;
                     if (nxt1.valid && nxt1.free) begin
                        seg_in.payload = merge1[AB-1:0];
                        tok_in.mode    = ffpa_pkg::MODE_DELETE;
                        tok_in.shift2  = 1'b0;
                     end else begin
                        tok_in.mode = ffpa_pkg::MODE_PASS;
                     end
                  end
               end
            end
            ffpa_pkg::MODE_INSERT: begin
               seg_in       = tok_i.carry;
               tok_in.carry = seg_ff;
               if (!seg_ff.valid) begin
                  tok_in.mode = ffpa_pkg::MODE_PASS;
               end
            end
            ffpa_pkg::MODE_DELETE: begin
               seg_in = tok_i.shift2 ? nxt2 : nxt1;
            end
            ffpa_pkg::MODE_PASS: begin
               seg_in = seg_ff;
            end
            default: begin
               seg_in = seg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
      if (init) begin
         seg_ff <= init_seg;
      end else begin
         seg_ff <= seg_in;
      end
   end

   assign seg_o = seg_ff;
   assign tok_o = tok_ff;

endmodule

// ===== rtl/first_fit_pool_allocator_top.sv =====
// Top level of the first-fit pool allocator: request launch, cell row and register port.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | req_payload (type, size, address)
//  rsp     | out       | rsp_valid/ready    | rsp_payload (address, status)
//  csr     | in/out    | psel/penable/pready| pool_size at byte address 0
//
// Each request's token walks the row of segment cells one cell per cycle,
// and the result is registered at the end. One request is in flight at a
// time; a new one is taken once the previous response has been accepted.
// Reset and a pool_size write reload the cells, leaving one free segment.
module first_fit_pool_allocator_top #(
   parameter int MAX_SEGMENTS = ffpa_pkg::MAX_SEGMENTS_DEF,
   parameter int HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffpa_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffpa_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int AB = ffpa_pkg::ADDR_BITS;
   localparam logic [AB-1:0] HDR = AB'(HEADER_BYTES);

   logic [15:0]       pool_size_ff, pool_size_in;
   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ffpa_pkg::rsp_type rsp_ff, rsp_in;
   ffpa_pkg::tok_type launch_ff, launch_in;
   logic              cfg_wr, init, req_acc, rsp_acc;
   logic [15:0]       init_pool;
   ffpa_pkg::seg_type head_seg;

   ffpa_pkg::tok_type tok_chain [MAX_SEGMENTS+1];
   ffpa_pkg::seg_type seg_chain [MAX_SEGMENTS+2];

   assign pready    = 1'b1;
   assign prdata    = {16'b0, pool_size_ff};
   assign cfg_wr    = psel && penable && pwrite && (paddr == 3'd0);
   assign init      = reset || cfg_wr;
   assign init_pool = reset ? 16'd0 : pwdata[15:0];

   always_comb begin
      head_seg.valid   = 1'b1;
      head_seg.free    = 1'b1;
      head_seg.start   = '0;
      head_seg.payload = (init_pool > HDR) ? (init_pool - HDR) : '0;
   end

   assign req_ready   = !busy_ff;
   assign req_acc     = req_valid && !busy_ff;
   assign rsp_acc     = rsp_valid_ff && rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      launch_in         = launch_ff;
      launch_in.active  = req_acc;
      launch_in.op_free = (req_payload.req_type == ffpa_pkg::REQ_FREE);
      launch_in.key     = launch_in.op_free ? req_payload.free_address
                                            : req_payload.alloc_size;
      launch_in.room    = !seg_chain[MAX_SEGMENTS-1].valid;
      launch_in.carry   = '0;
      launch_in.shift2  = 1'b0;
      launch_in.address = '0;
      launch_in.status  = ffpa_pkg::STATUS_OK;
      launch_in.mode    = ffpa_pkg::MODE_SEARCH;
      if (launch_in.key == '0) begin
         // A zero size is rejected; a null free does nothing.
         launch_in.mode   = ffpa_pkg::MODE_PASS;
         launch_in.status = launch_in.op_free ? ffpa_pkg::STATUS_OK
                                              : ffpa_pkg::STATUS_INVALID;
      end
   end

   assign tok_chain[0]               = launch_ff;
   assign seg_chain[MAX_SEGMENTS]    = '0;
   assign seg_chain[MAX_SEGMENTS+1]  = '0;

   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
      ffpa_cell #(
         .HEADER_BYTES(HEADER_BYTES)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .init     (init),
         .init_seg ((k == 0) ? head_seg : '0),
         .tok_i    (tok_chain[k]),
         .nxt1     (seg_chain[k+1]),
         .nxt2     (seg_chain[k+2]),
         .seg_o    (seg_chain[k]),
         .tok_o    (tok_chain[k+1])
      );
   end

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pool_size_in = cfg_wr ? pwdata[15:0] : pool_size_ff;
      if (req_acc) begin
         busy_in = 1'b1;
      end
      if (rsp_acc) begin
         rsp_valid_in = 1'b0;
         busy_in      = 1'b0;
      end
      if (tok_chain[MAX_SEGMENTS].active) begin
         rsp_valid_in = 1'b1;
         // A token still searching at the end of a full row found nothing.
         if (tok_chain[MAX_SEGMENTS].mode == ffpa_pkg::MODE_SEARCH) begin
            rsp_in.address = '0;
            rsp_in.status  = tok_chain[MAX_SEGMENTS].op_free ? ffpa_pkg::STATUS_BAD
                                                             : ffpa_pkg::STATUS_NO_FIT;
         end else begin
            rsp_in.address = tok_chain[MAX_SEGMENTS].address;
            rsp_in.status  = tok_chain[MAX_SEGMENTS].status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         launch_ff.active <= 1'b0;
         pool_size_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         launch_ff    <= launch_in;
         pool_size_ff <= pool_size_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

// ===== sim/testbench.sv =====
// Testbench for the first-fit pool allocator: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int SEGS   = ffpa_pkg::MAX_SEGMENTS_DEF;
   localparam int HDR    = ffpa_pkg::HEADER_BYTES_DEF;
   localparam int LIMIT  = 20000;
   localparam int SETTLE = SEGS + 8;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ffpa_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ffpa_pkg::rsp_type rsp_payload;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   first_fit_pool_allocator_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state: address-ordered segment list.
   typedef struct {
      int unsigned start;
      int unsigned payload;
      bit          is_free;
   } segment_type;

   segment_type       segments[$];
   int unsigned       pool_bytes;

   ffpa_pkg::req_type pending_requests[$];
   ffpa_pkg::rsp_type expected_responses[$];
   int                failures = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                quiet_cycles = 0;
   logic [15:0]       live_addrs[$];

   function automatic void reload_pool(int unsigned bytes);
      segment_type s;
      pool_bytes = bytes;
      s.start = 0;
      s.payload = (bytes > HDR) ? bytes - HDR : 0;
      s.is_free = 1'b1;
      segments = {s};
   endfunction

   function automatic ffpa_pkg::rsp_type predict_response(ffpa_pkg::req_type r);
      ffpa_pkg::rsp_type o;
      segment_type       n;
      int                i;
      o = '0;
      if (r.req_type == ffpa_pkg::REQ_ALLOC) begin
         if (r.alloc_size == 0) begin
            o.status = ffpa_pkg::STATUS_INVALID;
            return o;
         end
         o.status = ffpa_pkg::STATUS_NO_FIT;
         for (i = 0; i < segments.size(); i++) begin
            if (segments[i].is_free && segments[i].payload >= r.alloc_size) begin
               if (segments[i].payload > r.alloc_size + HDR && segments.size() < SEGS) begin
                  n.start = segments[i].start + HDR + r.alloc_size;
                  n.payload = segments[i].payload - r.alloc_size - HDR;
                  n.is_free = 1'b1;
                  segments[i].payload = r.alloc_size;
                  segments.insert(i + 1, n);
               end
               segments[i].is_free = 1'b0;
               o.address = 16'(segments[i].start + HDR);
               o.status = ffpa_pkg::STATUS_OK;
               break;
            end
         end
         return o;
      end
      o.status = ffpa_pkg::STATUS_OK;
      if (r.free_address == 0) return o;
      for (i = 0; i < segments.size(); i++)
         if (segments[i].start + HDR == r.free_address) break;
      if (i >= segments.size()) begin
         o.status = ffpa_pkg::STATUS_BAD;
         return o;
      end
      segments[i].is_free = 1'b1;
      if (i > 0 && segments[i-1].is_free) begin
         segments[i-1].payload += segments[i].payload + HDR;
         segments.delete(i);
         i--;
      end
      if (i + 1 < segments.size() && segments[i+1].is_free) begin
         segments[i].payload += segments[i+1].payload + HDR;
         segments.delete(i + 1);
      end
      return o;
   endfunction

   // Driver: holds valid with a stable payload until the request is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Prediction happens at acceptance so the state tracks the block in order.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_responses.push_back(predict_response(req_payload));
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor.
   always @(posedge clock) begin
      ffpa_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            $error("unexpected response address=%0d status=%0d",
                   rsp_payload.address, rsp_payload.status);
            failures++;
         end else begin
            e = expected_responses.pop_front();
            if (rsp_payload.address !== e.address) begin
               $error("address expected %0d actual %0d", e.address, rsp_payload.address);
               failures++;
            end
            if (rsp_payload.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_payload.status);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT) begin
         $display("FAIL first_fit_pool_allocator_top");
         $finish;
      end
   end

   task automatic drain();
      wait (pending_requests.size() == 0 && !req_valid);
      wait (expected_responses.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_pool_size(logic [15:0] bytes);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {16'd0, bytes};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      reload_pool(bytes);
   endtask

   function automatic ffpa_pkg::req_type make_alloc(logic [15:0] sz);
      ffpa_pkg::req_type r;
      r = '0;
      r.req_type = ffpa_pkg::REQ_ALLOC;
      r.alloc_size = sz;
      r.free_address = 16'($urandom);
      return r;
   endfunction

   function automatic ffpa_pkg::req_type make_free(logic [15:0] a);
      ffpa_pkg::req_type r;
      r = '0;
      r.req_type = ffpa_pkg::REQ_FREE;
      r.free_address = a;
      r.alloc_size = 16'($urandom);
      return r;
   endfunction

   // Mostly realistic alloc/free traffic, tracking granted addresses from the responses
   // in a shadow list so frees usually hit live segments.
   task automatic queue_random(int count);
      int          k;
      int unsigned pick;
      logic [15:0] sz;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            case ($urandom_range(9))
               0: sz = 16'($urandom);
               1: sz = 16'($urandom_range(1, 4));
               default: sz = 16'($urandom_range(1, 300));
            endcase
            pending_requests.push_back(make_alloc(sz));
         end else if (pick < 88) begin
            // A random offset rarely hits a segment, so reuse recently granted addresses.
            if (live_addrs.size() > 0)
               pending_requests.push_back(
                  make_free(live_addrs[$urandom_range(live_addrs.size()-1)]));
            else
               pending_requests.push_back(make_free(16'(HDR)));
         end else if (pick < 94) begin
            pending_requests.push_back(make_free(16'($urandom)));
         end else if (pick < 97) begin
            pending_requests.push_back(make_free(16'd0));
         end else begin
            pending_requests.push_back(make_alloc(16'd0));
         end
      end
   endtask

   // Records granted offsets so later frees target real segments.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_payload.status == ffpa_pkg::STATUS_OK
          && rsp_payload.address != 0) begin
         live_addrs.push_back(rsp_payload.address);
         if (live_addrs.size() > 80) void'(live_addrs.pop_front());
      end
   end

   task automatic run_phase(int idle, int stall, int count);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      queue_random(count);
      drain();
   endtask

   initial begin
      reload_pool(0);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Pool of zero bytes: every allocate misses.
      pending_requests.push_back(make_alloc(16'd1));
      pending_requests.push_back(make_alloc(16'hFFFF));
      drain();

      write_pool_size(16'd20);
      pending_requests.push_back(make_alloc(16'd1));
      drain();

      write_pool_size(16'hFFFF);
      pending_requests.push_back(make_alloc(16'd0));
      pending_requests.push_back(make_alloc(16'd100));
      pending_requests.push_back(make_alloc(16'd50));
      pending_requests.push_back(make_alloc(16'd1));
      pending_requests.push_back(make_free(16'd0));
      pending_requests.push_back(make_free(16'hFFFF));
      pending_requests.push_back(make_free(16'd25));
      pending_requests.push_back(make_free(16'(HDR + 124)));
      pending_requests.push_back(make_free(16'(HDR)));
      pending_requests.push_back(make_free(16'(HDR)));
      pending_requests.push_back(make_free(16'(HDR + 198)));
      pending_requests.push_back(make_alloc(16'(16'hFFFF - HDR)));
      pending_requests.push_back(make_alloc(16'(16'hFFFF - HDR)));
      pending_requests.push_back(make_free(16'(HDR)));
      drain();

      // Fill the table with tiny allocations so later grants go whole.
      write_pool_size(16'd4000);
      repeat (70) pending_requests.push_back(make_alloc(16'd1));
      pending_requests.push_back(make_free(16'(HDR + 25)));
      pending_requests.push_back(make_alloc(16'd1));
      drain();

      live_addrs.delete();
      write_pool_size(16'd3000);
      run_phase(0, 0, 250);
      run_phase(69, 0, 250);
      write_pool_size(16'(HDR + $urandom_range(0, 2000)));
      live_addrs.delete();
      run_phase(0, 69, 250);
      write_pool_size(16'hFFFF);
      live_addrs.delete();
      run_phase(31, 31, 250);
      write_pool_size(16'd1500);
      live_addrs.delete();
      run_phase(0, 0, 200);
      run_phase(31, 31, 200);

      if (failures == 0) begin
         $display("PASS first_fit_pool_allocator_top");
      end else begin
         $display("FAIL first_fit_pool_allocator_top");
      end
      $finish;
   end

endmodule
